// ===== design/dta_pkg.sv =====
// ----------------------------------------------------------------------------
// dta_pkg: shared types and constants for the descriptor table allocator
// Slot cell broadcast bus, chain links, command and status codes.
// ----------------------------------------------------------------------------
package dta_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int HANDLE_BITS = 12;
  localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
  localparam int LIMIT_BITS  = 7;
  localparam int ARG_BITS    = 8;
  localparam int CNT_BITS    = SLOT_BITS + 1;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(64);

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_DUP     = 3'd1,
    CMD_DUP_MIN = 3'd2,
    CMD_DUP_TO  = 3'd3,
    CMD_CLOSE   = 3'd4,
    CMD_GET     = 3'd5,
    CMD_SET     = 3'd6,
    CMD_CHECK   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADFD = 2'd1,
    ST_INVAL = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Broadcast from the control to every slot cell.
  typedef struct packed {
    logic                   claim_en;
    logic                   dst_en;
    logic                   clr_en;
    logic                   setx_en;
    logic                   xval;
    logic [HANDLE_BITS-1:0] data;
    logic [ARG_BITS-1:0]    src;
    logic [ARG_BITS-1:0]    dst;
    logic [ARG_BITS-1:0]    start;
    logic [LIMIT_BITS-1:0]  stop;
    logic [SLOT_BITS-1:0]   hint;
    logic [SLOT_BITS-1:0]   hu;
  } bcast_t;

  // Link that runs upward through the row (lowest slot first).
  typedef struct packed {
    logic                   free_seen;
    logic [SLOT_BITS-1:0]   slot;
    logic                   src_used;
    logic                   src_xc;
    logic [HANDLE_BITS-1:0] src_handle;
    logic                   dst_used;
    logic [HANDLE_BITS-1:0] dst_handle;
  } up_t;

  // Link that runs downward through the row (highest slot first).
  typedef struct packed {
    logic                 used_seen;
    logic [SLOT_BITS-1:0] hu;
  } dn_t;

endpackage

// ===== design/dta_cell.sv =====
// ----------------------------------------------------------------------------
// dta_cell: one descriptor slot
// Holds in-use, close-on-exec and handle; joins the up and down chains.
// ----------------------------------------------------------------------------
module dta_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [dta_pkg::SLOT_BITS-1:0]   idx,
  input  dta_pkg::bcast_t                 bc,
  input  dta_pkg::up_t                    up_i,
  output dta_pkg::up_t                    up_o,
  input  dta_pkg::dn_t                    dn_i,
  output dta_pkg::dn_t                    dn_o,
  output logic                            cnt_o
);

  logic                            used_r, used_nxt;
  logic                            xc_r, xc_nxt;
  logic [dta_pkg::HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [dta_pkg::ARG_BITS-1:0]    me;
  logic                            elig, take, src_hit, dst_hit, used_after, cand;

  assign me      = dta_pkg::ARG_BITS'(idx);
  assign src_hit = (bc.src == me);
  assign dst_hit = (bc.dst == me);
  assign elig    = !used_r && (me >= bc.start) && (me < dta_pkg::ARG_BITS'(bc.stop));
  assign take    = elig && !up_i.free_seen;
  assign cnt_o   = !used_r && (idx >= bc.hint) && (me < dta_pkg::ARG_BITS'(bc.stop));

  always_comb begin
    up_o            = up_i;
    up_o.free_seen  = up_i.free_seen | elig;
    if (take) begin
      up_o.slot = idx;
    end
    if (src_hit && used_r) begin
      up_o.src_used   = 1'b1;
      up_o.src_xc     = xc_r;
      up_o.src_handle = handle_r;
    end
    if (dst_hit && used_r) begin
      up_o.dst_used   = 1'b1;
      up_o.dst_handle = handle_r;
    end
  end

  // Walk-down after a close: highest used slot in 1..hu.
  assign used_after = used_r && !(bc.clr_en && src_hit);
  assign cand       = used_after && (idx != '0) && (idx <= bc.hu);
  always_comb begin
    dn_o           = dn_i;
    dn_o.used_seen = dn_i.used_seen | cand;
    if (cand && !dn_i.used_seen) begin
      dn_o.hu = idx;
    end
  end

  always_comb begin
    used_nxt   = used_r;
    xc_nxt     = xc_r;
    handle_nxt = handle_r;
    if ((bc.claim_en && take) || (bc.dst_en && dst_hit)) begin
      used_nxt   = 1'b1;
      xc_nxt     = 1'b0;
      handle_nxt = bc.data;
    end
    if (bc.clr_en && src_hit) begin
      used_nxt = 1'b0;
      xc_nxt   = 1'b0;
    end
    if (bc.setx_en && src_hit) begin
      xc_nxt = bc.xval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      xc_r   <= 1'b0;
    end else begin
      used_r <= used_nxt;
      xc_r   <= xc_nxt;
    end
    handle_r <= handle_nxt;
  end

endmodule

// ===== design/descriptor_table_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// descriptor_table_allocator_unit: descriptor slot table with allocator
// Row of slot cells with lowest-free search and highest-used walk-down.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------
//  command   | start, busy                | in_cmd .. in_arg_value
//  result    | out_strobe (one cycle)     | out_status .. out_answer_bit
//  config    | cfg_valid, cfg_ready       | cfg_data (open limit)
//
//  For each item, the accept cycle latches the command, the next cycle
//  runs it through the cell row (one search chain each way) and writes
//  the cells. The result strobes on the cycle after that. busy is high
//  for that one execute cycle; a new item may be accepted while the
//  previous result is on the ports. Reset is synchronous, active low,
//  and clears the table.
// ----------------------------------------------------------------------------
module descriptor_table_allocator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_cmd,
  input  logic [7:0]                      in_source_slot,
  input  logic [7:0]                      in_target_slot,
  input  logic [dta_pkg::HANDLE_BITS-1:0] in_new_handle,
  input  logic [7:0]                      in_arg_value,
  output logic                            out_strobe,
  output logic [1:0]                      out_status,
  output logic [5:0]                      out_slot_number,
  output logic [dta_pkg::HANDLE_BITS-1:0] out_slot_handle_out,
  output logic                            out_ref_added,
  output logic                            out_released,
  output logic [dta_pkg::HANDLE_BITS-1:0] out_released_handle,
  output logic                            out_answer_bit,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [6:0]                      cfg_data
);

  localparam int D  = dta_pkg::TABLE_DEPTH;
  localparam int SB = dta_pkg::SLOT_BITS;
  localparam int HB = dta_pkg::HANDLE_BITS;

  // Latched command.
  logic            exec_r;
  dta_pkg::cmd_t   cmd_r;
  logic [7:0]      src_r, dst_r, arg_r;
  logic [HB-1:0]   nh_r;
  logic [6:0]      limit_r;
  logic [SB-1:0]   hint_r, hint_nxt, hu_r, hu_nxt;

  // Result registers.
  logic            strobe_r;
  logic [1:0]      status_r, status_nxt;
  logic [5:0]      slot_r, slot_nxt;
  logic [HB-1:0]   hout_r, hout_nxt, relh_r, relh_nxt;
  logic            refadd_r, refadd_nxt, rel_r, rel_nxt, ans_r, ans_nxt;

  dta_pkg::bcast_t bc;
  dta_pkg::up_t    up [D+1];
  dta_pkg::dn_t    dn [D+1];
  logic [D-1:0]    cnt_bits;
  logic [dta_pkg::CNT_BITS-1:0] free_cnt;

  logic            accept;
  logic [7:0]      minimum, hint8;
  logic            src_ok, dst_in_lim, dup_inval, found;
  logic            is_dup, claim_ok, dst_write;

  assign accept    = start && !busy;
  assign busy      = exec_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r   <= 1'b0;
      strobe_r <= 1'b0;
      limit_r  <= dta_pkg::LIMIT_RESET;
      hint_r   <= '0;
      hu_r     <= '0;
    end else begin
      exec_r   <= accept;
      strobe_r <= exec_r;
      hint_r   <= hint_nxt;
      hu_r     <= hu_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
    end
  end

  // Hold the command for the execute cycle; capture the result fields in it.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= dta_pkg::cmd_t'(in_cmd);
      src_r <= in_source_slot;
      dst_r <= in_target_slot;
      arg_r <= in_arg_value;
      nh_r  <= in_new_handle;
    end
    if (exec_r) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      hout_r   <= hout_nxt;
      refadd_r <= refadd_nxt;
      rel_r    <= rel_nxt;
      relh_r   <= relh_nxt;
      ans_r    <= ans_nxt;
    end
  end

  // Search window and command decode.
  assign hint8      = 8'(hint_r);
  assign minimum    = (cmd_r == dta_pkg::CMD_DUP) ? 8'd0 : arg_r;
  assign src_ok     = up[D].src_used;
  assign found      = up[D].free_seen;
  assign dst_in_lim = dst_r < 8'(limit_r);
  assign dup_inval  = (cmd_r == dta_pkg::CMD_DUP_MIN) && (arg_r >= 8'(limit_r));
  assign is_dup     = (cmd_r == dta_pkg::CMD_DUP) || (cmd_r == dta_pkg::CMD_DUP_MIN);
  assign claim_ok   = exec_r && ((cmd_r == dta_pkg::CMD_ALLOC) ||
                                 (is_dup && src_ok && !dup_inval));
  assign dst_write  = exec_r && (cmd_r == dta_pkg::CMD_DUP_TO) && src_ok && dst_in_lim &&
                      (dst_r != src_r) && (dst_r < 8'(D));

  always_comb begin
    bc          = '0;
    bc.claim_en = claim_ok;
    bc.dst_en   = dst_write;
    bc.clr_en   = exec_r && (cmd_r == dta_pkg::CMD_CLOSE) && src_ok;
    bc.setx_en  = exec_r && (cmd_r == dta_pkg::CMD_SET) && src_ok;
    bc.xval     = arg_r[0];
    bc.data     = (cmd_r == dta_pkg::CMD_ALLOC) ? nh_r : up[D].src_handle;
    bc.src      = src_r;
    bc.dst      = dst_r;
    bc.start    = (minimum < hint8) ? hint8 : minimum;
    bc.stop     = (limit_r < 7'(D)) ? limit_r : 7'(D);
    bc.hint     = hint_r;
    bc.hu       = hu_r;
  end

  // Row of slot cells: up chain enters at slot 0, down chain at the top slot.
  assign up[0] = '0;
  assign dn[D] = '0;
  for (genvar i = 0; i < D; i++) begin : g_cell
    dta_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (SB'(i)),
      .bc    (bc),
      .up_i  (up[i]),
      .up_o  (up[i+1]),
      .dn_i  (dn[i+1]),
      .dn_o  (dn[i]),
      .cnt_o (cnt_bits[i])
    );
  end

  assign free_cnt = dta_pkg::CNT_BITS'($countones(cnt_bits));

  // Hint and highest-used updates.
  always_comb begin
    hint_nxt = hint_r;
    hu_nxt   = hu_r;
    if (claim_ok && found) begin
      if (minimum <= hint8) begin
        hint_nxt = up[D].slot;
      end
      if (up[D].slot > hu_r) begin
        hu_nxt = up[D].slot;
      end
    end
    if (dst_write && (dst_r[SB-1:0] > hu_r)) begin
      hu_nxt = dst_r[SB-1:0];
    end
    if (bc.clr_en) begin
      hu_nxt = dn[0].hu;
      if (src_r < hint8) begin
        hint_nxt = src_r[SB-1:0];
      end
    end
  end

  // Result fields; everything stays zero on an error.
  always_comb begin
    status_nxt = dta_pkg::ST_OK;
    slot_nxt   = '0;
    hout_nxt   = '0;
    refadd_nxt = 1'b0;
    rel_nxt    = 1'b0;
    relh_nxt   = '0;
    ans_nxt    = 1'b0;
    unique case (cmd_r)
      dta_pkg::CMD_ALLOC: begin
        if (!found) begin
          status_nxt = dta_pkg::ST_FULL;
        end else begin
          slot_nxt = 6'(up[D].slot);
          hout_nxt = nh_r;
        end
      end
      dta_pkg::CMD_DUP, dta_pkg::CMD_DUP_MIN: begin
        if (!src_ok) begin
          status_nxt = dta_pkg::ST_BADFD;
        end else if (dup_inval) begin
          status_nxt = dta_pkg::ST_INVAL;
        end else if (!found) begin
          status_nxt = dta_pkg::ST_FULL;
        end else begin
          slot_nxt   = 6'(up[D].slot);
          hout_nxt   = up[D].src_handle;
          refadd_nxt = 1'b1;
        end
      end
      dta_pkg::CMD_DUP_TO: begin
        if (!src_ok || !dst_in_lim) begin
          status_nxt = dta_pkg::ST_BADFD;
        end else if (dst_r == src_r) begin
          slot_nxt = dst_r[5:0];
          hout_nxt = up[D].src_handle;
        end else if (dst_r >= 8'(D)) begin
          status_nxt = dta_pkg::ST_FULL;
        end else begin
          slot_nxt   = dst_r[5:0];
          hout_nxt   = up[D].src_handle;
          refadd_nxt = 1'b1;
          rel_nxt    = up[D].dst_used;
          relh_nxt   = up[D].dst_used ? up[D].dst_handle : '0;
        end
      end
      dta_pkg::CMD_CLOSE: begin
        if (!src_ok) begin
          status_nxt = dta_pkg::ST_BADFD;
        end else begin
          rel_nxt  = 1'b1;
          relh_nxt = up[D].src_handle;
        end
      end
      dta_pkg::CMD_GET: begin
        if (!src_ok) begin
          status_nxt = dta_pkg::ST_BADFD;
        end else begin
          ans_nxt = up[D].src_xc;
        end
      end
      dta_pkg::CMD_SET: begin
        if (!src_ok) begin
          status_nxt = dta_pkg::ST_BADFD;
        end
      end
      dta_pkg::CMD_CHECK: begin
        ans_nxt = 8'(free_cnt) >= arg_r;
      end
      default: begin
        status_nxt = dta_pkg::ST_OK;
      end
    endcase
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_slot_number     = slot_r;
  assign out_slot_handle_out = hout_r;
  assign out_ref_added       = refadd_r;
  assign out_released        = rel_r;
  assign out_released_handle = relh_r;
  assign out_answer_bit      = ans_r;

endmodule

// ===== design/dta_checker.sv =====
// ----------------------------------------------------------------------------
// dta_checker: port-level checks for the descriptor table allocator
// Item timing and error-result shape, bound to the top level.
// ----------------------------------------------------------------------------
module dta_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [1:0] out_status,
  input logic [5:0] out_slot_number,
  input logic       out_ref_added,
  input logic       out_released
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("busy held longer than one cycle");

  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_strobe) else $error("result missing for item");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != dta_pkg::ST_OK) |->
      (out_slot_number == 6'd0) && !out_ref_added && !out_released)
    else $error("error result carries data");

endmodule

bind descriptor_table_allocator_unit dta_checker u_dta_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_status      (out_status),
  .out_slot_number (out_slot_number),
  .out_ref_added   (out_ref_added),
  .out_released    (out_released)
);
